/* rtl/scc_pkg.sv */
// Shared types and codes for the strongly connected components block
package scc_pkg;

	// vertex number as seen on the ports
	localparam int VW = 6;
	// counts that must hold the vertex count itself
	localparam int CW = 7;

	typedef logic [VW-1:0] vert_t;
	typedef logic [CW-1:0] cnt_t;

	// input item kinds
	localparam logic KIND_EDGE    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

endpackage

/* rtl/strongly_connected_components.sv */
// Channel   | Signals                                              | Direction
// ----------+------------------------------------------------------+----------
// item      | start, busy, kind, source_vertex, target_vertex      | in (busy out)
// result    | result_valid, edge_accepted, edge_error, vertex,     | out
//           | component_index, last_in_component, last             |
// config    | cfg_we, cfg_wdata (vertex_count)                     | in
//
// An edge beat reads the row and degree, then checks and stores; an edge
// with an endpoint out of range answers on the next cycle without going busy.
// A compute beat runs two depth-first passes on one sequencer: the first walks
// the stored out-edges of each vertex, and the second scans the transpose row one
// bit per cycle, pausing to read a new row when it takes an unvisited vertex.
// Reset is asynchronous, active low, and leaves the graph empty with MAX_VERTICES vertices.
// Results come as one-cycle strobes; the receiver cannot stall them.
module strongly_connected_components #(
	parameter int MAX_VERTICES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           kind,
	input  scc_pkg::vert_t source_vertex,
	input  scc_pkg::vert_t target_vertex,
	input  logic           cfg_we,
	input  scc_pkg::cnt_t  cfg_wdata,
	output logic           result_valid,
	output logic           edge_accepted,
	output logic           edge_error,
	output scc_pkg::vert_t vertex,
	output scc_pkg::vert_t component_index,
	output logic           last_in_component,
	output logic           last
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int SW = AW + scc_pkg::CW;
	localparam scc_pkg::cnt_t MAXC = scc_pkg::cnt_t'(MAX_VERTICES);
	localparam scc_pkg::cnt_t ONE  = scc_pkg::cnt_t'(1);
	localparam scc_pkg::cnt_t TWO  = scc_pkg::cnt_t'(2);

	typedef logic [AW-1:0] idx_t;
	typedef logic [MAX_VERTICES-1:0] row_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_E_RD, ST_E_CHK,
		ST_F_START, ST_F_RD, ST_F_EDGE, ST_F_POP,
		ST_S_POPF, ST_S_TAKE, ST_S_RROW, ST_S_SCAN, ST_S_POP
	} state_t;

	state_t state_q;

	// control and walk registers
	scc_pkg::cnt_t n_q;
	scc_pkg::vert_t src_q, tgt_q;
	row_t visited_q;
	row_t row_vld_q, deg_vld_q;
	scc_pkg::cnt_t s_q, sp_q, fc_q;
	idx_t top_v_q;
	scc_pkg::cnt_t top_i_q;
	scc_pkg::vert_t comp_q;

	// pending result, held until its flags are known
	logic pend_vld_q, pend_lic_q;
	idx_t pend_v_q;
	scc_pkg::vert_t pend_c_q;

	// result registers
	logic res_vld_q, res_acc_q, res_err_q, res_lic_q, res_last_q;
	scc_pkg::vert_t res_v_q, res_c_q;

	// memories
	idx_t tgt_mem [2**(2*AW)];
	scc_pkg::cnt_t deg_mem [MAX_VERTICES];
	row_t row_mem [MAX_VERTICES];
	logic [SW-1:0] walk_mem [MAX_VERTICES];
	idx_t fin_mem [MAX_VERTICES];

	idx_t tgt_rd_q, fin_rd_q;
	scc_pkg::cnt_t deg_rd_q;
	row_t row_rd_q;
	logic [SW-1:0] walk_rd_q;
	logic deg_ok_q, row_ok_q;

	// datapath
	idx_t src_i, tgt_i, row_ra, deg_ra, emit_v;
	logic [2*AW-1:0] tgt_ra;
	scc_pkg::cnt_t sp_m1, sp_m2, fc_m1, deg_cur;
	row_t row_cur, row_new;
	logic edge_dup, f_more, f_t_ok, s_in, s_hit, take_ok, emit_go;
	logic walk_we, fin_we, store_we, src_bad;
	scc_pkg::cnt_t cfg_n;

	assign src_i  = src_q[AW-1:0];
	assign tgt_i  = tgt_q[AW-1:0];
	assign row_ra = (state_q == ST_E_RD) ? tgt_i : top_v_q;
	assign deg_ra = (state_q == ST_E_RD) ? src_i : top_v_q;
	assign tgt_ra = {top_v_q, top_i_q[AW-1:0]};
	assign sp_m1  = sp_q - ONE;
	assign sp_m2  = sp_q - TWO;
	assign fc_m1  = fc_q - ONE;

	assign deg_cur  = deg_ok_q ? deg_rd_q : '0;
	assign row_cur  = row_ok_q ? row_rd_q : '0;
	assign edge_dup = row_cur[src_i] || (deg_cur >= MAXC);

	// first pass: next out-edge of the top vertex
	assign f_more = top_i_q < deg_cur;
	assign f_t_ok = (scc_pkg::cnt_t'(tgt_rd_q) < n_q) && !visited_q[tgt_rd_q] && (sp_q < MAXC);

	// second pass: one bit of the transpose row per cycle until an unvisited vertex is taken
	assign s_in  = top_i_q < n_q;
	assign s_hit = s_in && row_cur[top_i_q[AW-1:0]] && !visited_q[top_i_q[AW-1:0]]
		&& (sp_q < MAXC);
	assign take_ok = (scc_pkg::cnt_t'(fin_rd_q) < n_q) && !visited_q[fin_rd_q];

	assign emit_go = ((state_q == ST_S_TAKE) && take_ok) || ((state_q == ST_S_SCAN) && s_hit);
	assign emit_v  = (state_q == ST_S_TAKE) ? fin_rd_q : top_i_q[AW-1:0];

	assign walk_we  = ((state_q == ST_F_EDGE) && f_more && f_t_ok) ||
		((state_q == ST_S_SCAN) && s_hit);
	assign fin_we   = (state_q == ST_F_EDGE) && !f_more && (fc_q < MAXC);
	assign store_we = (state_q == ST_E_CHK) && !edge_dup;

	assign src_bad = (scc_pkg::cnt_t'(source_vertex) >= n_q) ||
		(scc_pkg::cnt_t'(target_vertex) >= n_q);

	// new row with the source bit set
	always_comb begin
		row_new = row_cur;
		row_new[src_i] = 1'b1;
	end

	// clamp of the written vertex count
	always_comb begin
		cfg_n = cfg_wdata;
		if (cfg_wdata == '0) cfg_n = ONE;
		else if (cfg_wdata > MAXC) cfg_n = MAXC;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (store_we) begin
			tgt_mem[{src_i, deg_cur[AW-1:0]}] <= tgt_i;
			deg_mem[src_i] <= deg_cur + ONE;
			row_mem[tgt_i] <= row_new;
		end
		if (walk_we) walk_mem[sp_m1[AW-1:0]] <= {top_v_q, top_i_q + ONE};
		if (fin_we) fin_mem[fc_q[AW-1:0]] <= top_v_q;
		tgt_rd_q  <= tgt_mem[tgt_ra];
		deg_rd_q  <= deg_mem[deg_ra];
		row_rd_q  <= row_mem[row_ra];
		deg_ok_q  <= deg_vld_q[deg_ra];
		row_ok_q  <= row_vld_q[row_ra];
		walk_rd_q <= walk_mem[sp_m2[AW-1:0]];
		fin_rd_q  <= fin_mem[fc_m1[AW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= MAXC;
			src_q      <= '0;
			tgt_q      <= '0;
			visited_q  <= '0;
			row_vld_q  <= '0;
			deg_vld_q  <= '0;
			s_q        <= '0;
			sp_q       <= '0;
			fc_q       <= '0;
			top_v_q    <= '0;
			top_i_q    <= '0;
			comp_q     <= '0;
			pend_vld_q <= 1'b0;
			pend_lic_q <= 1'b0;
			pend_v_q   <= '0;
			pend_c_q   <= '0;
			res_vld_q  <= 1'b0;
			res_acc_q  <= 1'b0;
			res_err_q  <= 1'b0;
			res_lic_q  <= 1'b0;
			res_last_q <= 1'b0;
			res_v_q    <= '0;
			res_c_q    <= '0;
		end else begin
			res_vld_q <= 1'b0;
			if (cfg_we) n_q <= cfg_n;

			// a new component member pushes out the one before it
			if (emit_go) begin
				if (pend_vld_q) begin
					res_vld_q  <= 1'b1;
					res_acc_q  <= 1'b0;
					res_err_q  <= 1'b0;
					res_v_q    <= scc_pkg::vert_t'(pend_v_q);
					res_c_q    <= pend_c_q;
					res_lic_q  <= pend_lic_q;
					res_last_q <= 1'b0;
				end
				pend_vld_q <= 1'b1;
				pend_lic_q <= 1'b0;
				pend_v_q   <= emit_v;
				pend_c_q   <= comp_q;
				visited_q[emit_v] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						src_q <= source_vertex;
						tgt_q <= target_vertex;
						if (kind == scc_pkg::KIND_EDGE) begin
							if (src_bad) begin
								res_vld_q  <= 1'b1;
								res_acc_q  <= 1'b0;
								res_err_q  <= 1'b1;
								res_v_q    <= '0;
								res_c_q    <= '0;
								res_lic_q  <= 1'b0;
								res_last_q <= 1'b1;
							end else begin
								state_q <= ST_E_RD;
							end
						end else begin
							visited_q <= '0;
							fc_q      <= '0;
							s_q       <= '0;
							state_q   <= ST_F_START;
						end
					end
				end
				ST_E_RD: state_q <= ST_E_CHK;
				ST_E_CHK: begin
					res_vld_q  <= 1'b1;
					res_acc_q  <= !edge_dup;
					res_err_q  <= 1'b0;
					res_v_q    <= '0;
					res_c_q    <= '0;
					res_lic_q  <= 1'b0;
					res_last_q <= 1'b1;
					if (!edge_dup) begin
						row_vld_q[tgt_i] <= 1'b1;
						deg_vld_q[src_i] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				// first pass: roots in ascending order
				ST_F_START: begin
					if (s_q >= n_q) begin
						visited_q <= '0;
						comp_q    <= '0;
						state_q   <= ST_S_POPF;
					end else if (visited_q[s_q[AW-1:0]]) begin
						s_q <= s_q + ONE;
					end else begin
						visited_q[s_q[AW-1:0]] <= 1'b1;
						top_v_q <= s_q[AW-1:0];
						top_i_q <= '0;
						sp_q    <= ONE;
						state_q <= ST_F_RD;
					end
				end
				ST_F_RD: state_q <= ST_F_EDGE;
				ST_F_EDGE: begin
					if (f_more) begin
						if (f_t_ok) begin
							visited_q[tgt_rd_q] <= 1'b1;
							top_v_q <= tgt_rd_q;
							top_i_q <= '0;
							sp_q    <= sp_q + ONE;
						end else begin
							top_i_q <= top_i_q + ONE;
						end
						state_q <= ST_F_RD;
					end else begin
						if (fc_q < MAXC) fc_q <= fc_q + ONE;
						sp_q <= sp_m1;
						if (sp_q == ONE) begin
							s_q     <= s_q + ONE;
							state_q <= ST_F_START;
						end else begin
							state_q <= ST_F_POP;
						end
					end
				end
				ST_F_POP: begin
					{top_v_q, top_i_q} <= walk_rd_q;
					state_q <= ST_F_RD;
				end
				// second pass: roots from the finish stack
				ST_S_POPF: begin
					if (fc_q == '0) begin
						res_vld_q  <= pend_vld_q;
						res_acc_q  <= 1'b0;
						res_err_q  <= 1'b0;
						res_v_q    <= scc_pkg::vert_t'(pend_v_q);
						res_c_q    <= pend_c_q;
						res_lic_q  <= pend_lic_q;
						res_last_q <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						fc_q    <= fc_m1;
						state_q <= ST_S_TAKE;
					end
				end
				ST_S_TAKE: begin
					if (take_ok) begin
						top_v_q <= fin_rd_q;
						top_i_q <= '0;
						sp_q    <= ONE;
						state_q <= ST_S_RROW;
					end else begin
						state_q <= ST_S_POPF;
					end
				end
				ST_S_RROW: state_q <= ST_S_SCAN;
				ST_S_SCAN: begin
					if (s_hit) begin
						top_v_q <= top_i_q[AW-1:0];
						top_i_q <= '0;
						sp_q    <= sp_q + ONE;
						state_q <= ST_S_RROW;
					end else if (s_in && !(row_cur[top_i_q[AW-1:0]] &&
						!visited_q[top_i_q[AW-1:0]])) begin
						top_i_q <= top_i_q + ONE;
					end else begin
						sp_q <= sp_m1;
						if (sp_q == ONE) begin
							pend_lic_q <= 1'b1;
							comp_q     <= comp_q + scc_pkg::vert_t'(1);
							state_q    <= ST_S_POPF;
						end else begin
							state_q <= ST_S_POP;
						end
					end
				end
				ST_S_POP: begin
					{top_v_q, top_i_q} <= walk_rd_q;
					state_q <= ST_S_RROW;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign result_valid      = res_vld_q;
	assign edge_accepted     = res_acc_q;
	assign edge_error        = res_err_q;
	assign vertex            = res_v_q;
	assign component_index   = res_c_q;
	assign last_in_component = res_lic_q;
	assign last              = res_last_q;

endmodule

/* rtl/scc_chk.sv */
// Port-level checks for the strongly connected components block
module scc_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           kind,
	input scc_pkg::vert_t source_vertex,
	input scc_pkg::vert_t target_vertex,
	input logic           cfg_we,
	input scc_pkg::cnt_t  cfg_wdata,
	input logic           result_valid,
	input logic           edge_accepted,
	input logic           edge_error,
	input scc_pkg::vert_t vertex,
	input scc_pkg::vert_t component_index,
	input logic           last_in_component,
	input logic           last
);

	// an accepted beat either goes busy or answers at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || result_valid)
		else $error("accepted beat produced neither busy nor a result");

	// edge results are single and never both flags
	a_edge_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (edge_accepted || edge_error) |-> last && !(edge_accepted && edge_error))
		else $error("bad edge result flags");

	// more results pending means the block is still working
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result while idle");

endmodule

bind strongly_connected_components scc_chk u_scc_chk (.*);
